// ===== hw/rtl/met_pkg.sv =====
// met_pkg: types, constants and control structs for the escape-time block
// no dependencies; imported by every module of the block

package met_pkg;

  localparam int ITER_CAP   = 256;
  localparam int FRAC_BITS  = 28;
  localparam int GRAY_SCALE = 255;

  // |z| stays below 2^31 + 2^(FRAC_BITS+2) while no escape has been seen
  localparam int MAG_W = (((FRAC_BITS + 3) > 31) ? (FRAC_BITS + 3) : 31) + 1;
  localparam int Z_W   = MAG_W + 1;
  localparam int PR_W  = 2 * MAG_W;
  localparam int SQ_W  = PR_W - FRAC_BITS;
  localparam int XT_W  = SQ_W + 1;
  localparam int SUM_W = XT_W + 2;

  localparam int CNT_W = $clog2(ITER_CAP + 1);
  localparam int IDX_W = (ITER_CAP > 1) ? $clog2(ITER_CAP) : 1;
  localparam int GP_W  = CNT_W + 8;

  localparam logic [SQ_W:0] ESC_LIMIT = (SQ_W + 1)'(4) << FRAC_BITS;

  typedef struct packed {
    logic signed [31:0] c_real;
    logic signed [31:0] c_imag;
  } met_in_t;

  typedef struct packed {
    logic [8:0] iter_count;
    logic       inside_set;
    logic [7:0] gray;
  } met_out_t;

  typedef struct packed {
    logic load;
    logic mul_en;
    logic upd;
  } met_ctrl_t;

  typedef struct packed {
    logic escaped;
  } met_stat_t;

endpackage

// ===== hw/rtl/mandelbrot_escape_time_gray.sv =====
// mandelbrot_escape_time_gray: escape-time count and gray level for one point
// depends on met_pkg, met_iter, met_seq
//
//   channel  ports                          beat
//   in       in_valid in_ready in_data      c_real, c_imag (signed q3.28)
//   out      out_valid out_ready out_data   iter_count, inside_set, gray
//
// a point runs until escape, at most ITER_CAP iterations;
// one multiply step and one add/test step per iteration
// one point in flight; in_ready is high only between points
// the result register frees the datapath: a new point is taken while a result waits
// a point that finishes while the result register is full holds until it drains
// rst_n is synchronous; no clearing pass

module mandelbrot_escape_time_gray import met_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  met_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output met_out_t out_data
);

  met_ctrl_t ctrl;
  met_stat_t stat;

  met_iter u_iter (
    .clk     (clk),
    .ctrl    (ctrl),
    .in_data (in_data),
    .stat    (stat)
  );

  met_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .stat      (stat),
    .ctrl      (ctrl),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== hw/rtl/met_iter.sv =====
// met_iter: shared square-and-add datapath, one multiply step then one add step
// depends on met_pkg; driven by met_seq

module met_iter import met_pkg::*; (
  input  logic      clk,
  input  met_ctrl_t ctrl,
  input  met_in_t   in_data,
  output met_stat_t stat
);

  logic signed [31:0]    cr_r, ci_r;
  logic signed [Z_W-1:0] zr_r, zi_r;
  logic [SQ_W-1:0]       mr_r, mi_r;
  logic [XT_W-1:0]       t_r;
  logic                  tneg_r;

  logic signed [Z_W-1:0]   zr_neg, zi_neg;
  logic [MAG_W-1:0]        mag_r, mag_i;
  logic [PR_W-1:0]         prod_rr, prod_ii, prod_ri;
  logic signed [SUM_W-1:0] sum_r, sum_i, t_s;
  logic [SQ_W:0]           msum;

  // magnitudes and the three products of the current z
  always_comb begin
    zr_neg  = -zr_r;
    zi_neg  = -zi_r;
    mag_r   = zr_r[Z_W-1] ? MAG_W'(zr_neg) : MAG_W'(zr_r);
    mag_i   = zi_r[Z_W-1] ? MAG_W'(zi_neg) : MAG_W'(zi_r);
    prod_rr = PR_W'(mag_r) * PR_W'(mag_r);
    prod_ii = PR_W'(mag_i) * PR_W'(mag_i);
    prod_ri = PR_W'(mag_r) * PR_W'(mag_i);
  end

  // update from the registered products
  always_comb begin
    t_s   = tneg_r ? -$signed({2'b00, t_r}) : $signed({2'b00, t_r});
    sum_r = $signed({3'b000, mr_r}) - $signed({3'b000, mi_r}) + SUM_W'(cr_r);
    sum_i = t_s + SUM_W'(ci_r);
    msum  = (SQ_W + 1)'(mr_r) + (SQ_W + 1)'(mi_r);
  end

  assign stat.escaped = (msum > ESC_LIMIT);

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cr_r <= in_data.c_real;
      ci_r <= in_data.c_imag;
      zr_r <= Z_W'(in_data.c_real);
      zi_r <= Z_W'(in_data.c_imag);
    end else if (ctrl.upd) begin
      zr_r <= Z_W'(sum_r);
      zi_r <= Z_W'(sum_i);
    end
    if (ctrl.mul_en) begin
      mr_r   <= SQ_W'(prod_rr >> FRAC_BITS);
      mi_r   <= SQ_W'(prod_ii >> FRAC_BITS);
      t_r    <= XT_W'(prod_ri >> (FRAC_BITS - 1));
      tneg_r <= zr_r[Z_W-1] ^ zi_r[Z_W-1];
    end
  end

endmodule

// ===== hw/rtl/met_seq.sv =====
// met_seq: sequencer, iteration counter, gray mapping and result register
// depends on met_pkg; steers met_iter

module met_seq import met_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  met_stat_t stat,
  output met_ctrl_t ctrl,
  output logic      out_valid,
  input  logic      out_ready,
  output met_out_t  out_data
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_MUL  = 3'b010,
    S_CHK  = 3'b100
  } met_state_t;

  met_state_t       state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             out_valid_r, out_valid_nxt;
  met_out_t         out_data_r, out_data_nxt;

  logic             done;
  logic             in_set;
  logic [CNT_W-1:0] cnt;
  logic [GP_W-1:0]  gp;

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    ctrl          = '0;

    done   = stat.escaped || (idx_r == IDX_W'(ITER_CAP - 1));
    in_set = !stat.escaped;
    cnt    = stat.escaped ? CNT_W'(idx_r) : CNT_W'(ITER_CAP);
    gp     = GP_W'(cnt) * GP_W'(GRAY_SCALE);

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ctrl.load = 1'b1;
          idx_nxt   = '0;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        ctrl.mul_en = 1'b1;
        state_nxt   = S_CHK;
      end
      S_CHK: begin
        if (done) begin
          // hold until the result register is free
          if (!out_valid_nxt) begin
            out_valid_nxt           = 1'b1;
            out_data_nxt.iter_count = 9'(cnt);
            out_data_nxt.inside_set = in_set;
            out_data_nxt.gray       = in_set ? 8'd0 : 8'(gp / GP_W'(ITER_CAP));
            state_nxt               = S_IDLE;
          end
        end else begin
          ctrl.upd  = 1'b1;
          idx_nxt   = IDX_W'(idx_r + 1'b1);
          state_nxt = S_MUL;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r      <= idx_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== hw/rtl/met_chk.sv =====
// met_chk: port-level checks for mandelbrot_escape_time_gray, bound to the top level
// depends on met_pkg

module met_chk import met_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_ready,
  input met_in_t  in_data,
  input logic     out_valid,
  input logic     out_ready,
  input met_out_t out_data
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // busy after taking a point
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready right after accepting a point");

  // no result in the cycle after a point is taken
  a_no_fast: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_valid |=> !out_valid)
    else $error("result appeared too early");

  // inside flag matches the count
  a_inside: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.inside_set == (out_data.iter_count == 9'(ITER_CAP))))
    else $error("inside_set disagrees with iter_count");

  // points in the set are black
  a_gray: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.inside_set |-> (out_data.gray == 8'd0))
    else $error("nonzero gray for a point in the set");

endmodule

bind mandelbrot_escape_time_gray met_chk u_met_chk (.*);

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// tb: self-checking bench for mandelbrot_escape_time_gray; predicts each point's
// escape count and gray level in 64-bit fixed point and checks every beat
// depends on met_pkg and the rtl of mandelbrot_escape_time_gray

module tb;
  import met_pkg::*;

  localparam int HOLD_CYCLES = 1500;
  localparam int IDLE_PCT    = 37;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  met_in_t  in_data   = '0;
  logic     out_ready = 1'b0;
  logic     in_ready;
  logic     out_valid;
  met_out_t out_data;

  met_out_t pending_levels[$];
  int       mismatches = 0;
  bit       gapless    = 1'b0;
  int       hold_asked = 0;
  int       hold_seen  = 0;
  int       hold_left  = 0;

  mandelbrot_escape_time_gray u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #4 clk = ~clk;

  function automatic logic [63:0] abs64(input logic [63:0] x);
    return x[63] ? -x : x;
  endfunction

  // floor(a * b / 2^FRAC_BITS), product kept exact at 128 bits
  function automatic logic [63:0] mul_frac(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[FRAC_BITS +: 64];
  endfunction

  function automatic met_out_t escape_gray(input met_in_t pt);
    logic [63:0] cr, ci, zr, zi, mr, mi, xt;
    int          cnt;
    met_out_t    r;
    cr  = {{32{pt.c_real[31]}}, pt.c_real};
    ci  = {{32{pt.c_imag[31]}}, pt.c_imag};
    zr  = '0;
    zi  = '0;
    mr  = '0;
    mi  = '0;
    cnt = ITER_CAP;
    for (int k = 0; k < ITER_CAP; k++) begin
      xt = mul_frac(abs64(zr) << 1, abs64(zi));
      if (zr[63] != zi[63]) xt = -xt;
      zr = mr - mi + cr;
      zi = xt + ci;
      mr = mul_frac(abs64(zr), abs64(zr));
      mi = mul_frac(abs64(zi), abs64(zi));
      if (mr + mi > (64'd4 << FRAC_BITS)) begin
        cnt = k;
        break;
      end
    end
    r.iter_count = 9'(cnt);
    r.inside_set = (cnt >= ITER_CAP);
    r.gray       = (cnt >= ITER_CAP) ? 8'd0 : 8'((GRAY_SCALE * cnt) / ITER_CAP);
    return r;
  endfunction

  function automatic logic [31:0] q(input real r);
    return 32'($rtoi(r * (2.0 ** FRAC_BITS)));
  endfunction

  function automatic met_in_t point(input logic [31:0] re, input logic [31:0] im);
    met_in_t p;
    p.c_real = re;
    p.c_imag = im;
    return p;
  endfunction

  // mostly the box around the set, some raw 32-bit patterns
  function automatic met_in_t random_point();
    if ($urandom_range(99) < 85)
      return point($urandom_range(32'd805306368) - 32'd603979776,
                   $urandom_range(32'd805306368) - 32'd402653184);
    return point($urandom, $urandom);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
  endtask

  task automatic send_point(input met_in_t pt);
    while (!gapless && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= pt;
    do @(posedge clk); while (!in_ready);
    pending_levels.push_back(escape_gray(pt));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_levels.size() != 0) @(posedge clk);
  endtask

  // result side: random stalls, gapless stretch, long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_seen != hold_asked) begin
      hold_seen <= hold_asked;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= gapless || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    met_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_levels.size() == 0) begin
        report_mismatch("unexpected beat, iter_count", out_data.iter_count, -1);
      end else begin
        want = pending_levels.pop_front();
        if (out_data.iter_count != want.iter_count)
          report_mismatch("iter_count", out_data.iter_count, want.iter_count);
        if (out_data.inside_set != want.inside_set)
          report_mismatch("inside_set", out_data.inside_set, want.inside_set);
        if (out_data.gray != want.gray)
          report_mismatch("gray", out_data.gray, want.gray);
      end
    end
  end

  task automatic test_directed();
    send_point(point(32'h0000_0000, 32'h0000_0000));
    send_point(point(32'h7fff_ffff, 32'h7fff_ffff));
    send_point(point(32'h8000_0000, 32'h8000_0000));
    send_point(point(32'h7fff_ffff, 32'h8000_0000));
    send_point(point(32'h8000_0000, 32'h7fff_ffff));
    send_point(point(32'h8000_0000, 32'h0000_0000));
    send_point(point(32'h0000_0000, 32'h7fff_ffff));
    send_point(point(q(-2.0), 32'h0000_0000));
    send_point(point(q(2.0), 32'h0000_0000));
    send_point(point(q(1.0), 32'h0000_0000));
    send_point(point(q(-1.0), 32'h0000_0000));
    send_point(point(q(-1.5), 32'h0000_0000));
    send_point(point(q(0.25), 32'h0000_0000));
    send_point(point(q(0.26), 32'h0000_0000));
    send_point(point(32'h0000_0000, q(1.0)));
    send_point(point(32'h0000_0000, q(-1.0)));
    send_point(point(q(-0.75), q(0.1)));
    send_point(point(q(0.5), q(0.5)));
    send_point(point(q(-0.1), q(0.65)));
    send_point(point(q(0.3), q(0.5)));
    send_point(point(q(-2.0), 32'h0000_0001));
    drain();
  endtask

  task automatic test_region(input int n);
    repeat (n) send_point(random_point());
    drain();
  endtask

  task automatic test_stall_fill();
    hold_asked <= hold_asked + 1;
    repeat (24) send_point(random_point());
    drain();
  endtask

  task automatic test_gapless(input int n);
    gapless = 1'b1;
    repeat (n) send_point(random_point());
    drain();
    gapless = 1'b0;
  endtask

  task automatic test_full_range(input int n);
    repeat (n) send_point(point($urandom, $urandom));
    drain();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_region(1000);
    test_stall_fill();
    test_gapless(200);
    test_full_range(300);
    repeat (2 * ITER_CAP + 1) @(posedge clk);
    if (mismatches == 0 && pending_levels.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #50_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
